// ----- design/pps_bsl_pkg.sv -----
// Package: item types and constants for the PPS drive binary search loop.
`timescale 1ns / 1ps
`default_nettype none

package pps_bsl_pkg;

    localparam logic [1:0] OP_MEASURE = 2'd0;
    localparam logic [1:0] OP_SET_MODE = 2'd1;
    localparam logic [1:0] OP_DRIVE = 2'd2;

    localparam logic [7:0] MODE_HOST = 8'd0;
    localparam logic [7:0] MODE_AUTO = 8'd1;

    localparam logic [6:0] THRESHOLD_RESET = 7'd10;
    localparam logic [3:0] STEP_EXP_RESET = 4'd15;
    localparam logic [15:0] DRIVE_RESET = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] phase_diff;
        logic [7:0]         new_mode;
        logic [15:0]        direct_drive;
    } in_item_t;

    typedef struct packed {
        logic               drive_written;
        logic [15:0]        drive_value;
        logic [7:0]         mode_now;
        logic [7:0]         probe_count;
        logic signed [15:0] last_phase;
        logic signed [7:0]  error_sum;
        logic [3:0]         step_position;
        logic [15:0]        search_drive;
        logic [15:0]        settle_count;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/pps_bsl_in_if.sv -----
// Interface: valid/ready channel carrying one input item.
`timescale 1ns / 1ps
`default_nettype none

interface pps_bsl_in_if;
    logic                    valid;
    logic                    ready;
    pps_bsl_pkg::in_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/pps_bsl_out_if.sv -----
// Interface: valid/ready channel carrying one result item.
`timescale 1ns / 1ps
`default_nettype none

interface pps_bsl_out_if;
    logic                    valid;
    logic                    ready;
    pps_bsl_pkg::out_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/pps_bsl_core.sv -----
// Search state registers and the single-pass update for one item.
`timescale 1ns / 1ps
`default_nettype none

module pps_bsl_core
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [6:0]             cfg_wdata,
    input  wire logic                   item_go,
    input  wire pps_bsl_pkg::in_item_t  item,
    output pps_bsl_pkg::out_item_t      res
);

    logic [6:0]         thr_reg;
    logic [7:0]         mode_reg, mode_next;
    logic [7:0]         accum_reg, accum_next;
    logic [3:0]         exp_reg, exp_next;
    logic [15:0]        search_reg, search_next;
    logic [15:0]        since_reg, since_next;
    logic [7:0]         probes_reg, probes_next;
    logic [15:0]        phase_reg, phase_next;
    logic [15:0]        drive_reg, drive_next;
    logic               written;

    logic [7:0]         acc_sum;
    logic signed [7:0]  thr_pos;
    logic signed [7:0]  thr_neg;
    logic [15:0]        delta;
    logic               above;
    logic               below;

    assign acc_sum = accum_reg + item.phase_diff[7:0];
    assign thr_pos = $signed({1'b0, thr_reg});
    assign thr_neg = -thr_pos;
    assign delta = 16'd1 << exp_reg;
    assign above = $signed(acc_sum) > thr_pos;
    assign below = $signed(acc_sum) < thr_neg;

    always_comb
    begin
        mode_next = mode_reg;
        accum_next = accum_reg;
        exp_next = exp_reg;
        search_next = search_reg;
        since_next = since_reg;
        probes_next = probes_reg;
        phase_next = phase_reg;
        drive_next = drive_reg;
        written = 1'b0;
        case (item.op)
            pps_bsl_pkg::OP_MEASURE:
            begin
                probes_next = probes_reg + 8'd1;
                phase_next = item.phase_diff;
                if (mode_reg == pps_bsl_pkg::MODE_AUTO)
                begin
                    accum_next = acc_sum;
                    since_next = since_reg + 16'd1;
                    if (above || below)
                    begin
                        search_next = above ? search_reg - delta : search_reg + delta;
                        exp_next = (exp_reg != 4'd0) ? exp_reg - 4'd1 : exp_reg;
                        drive_next = search_next;
                        accum_next = 8'd0;
                        since_next = 16'd0;
                        written = 1'b1;
                    end
                end
            end
            pps_bsl_pkg::OP_SET_MODE:
            begin
                mode_next = item.new_mode;
                if (item.new_mode == pps_bsl_pkg::MODE_AUTO)
                begin
                    accum_next = 8'd0;
                    exp_next = pps_bsl_pkg::STEP_EXP_RESET;
                    search_next = pps_bsl_pkg::DRIVE_RESET;
                    since_next = 16'd0;
                    drive_next = pps_bsl_pkg::DRIVE_RESET;
                    written = 1'b1;
                end
            end
            pps_bsl_pkg::OP_DRIVE:
            begin
                drive_next = item.direct_drive;
                written = 1'b1;
            end
            default:
            begin
                written = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.drive_written = written;
        res.drive_value = drive_next;
        res.mode_now = mode_next;
        res.probe_count = probes_next;
        res.last_phase = $signed(phase_next);
        res.error_sum = $signed(accum_next);
        res.step_position = exp_next;
        res.search_drive = search_next;
        res.settle_count = since_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= pps_bsl_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pps_bsl_pkg::MODE_AUTO;
            accum_reg <= 8'd0;
            exp_reg <= pps_bsl_pkg::STEP_EXP_RESET;
            search_reg <= pps_bsl_pkg::DRIVE_RESET;
            since_reg <= 16'd0;
            probes_reg <= 8'd0;
            phase_reg <= 16'd0;
            drive_reg <= pps_bsl_pkg::DRIVE_RESET;
        end
        else if (item_go)
        begin
            mode_reg <= mode_next;
            accum_reg <= accum_next;
            exp_reg <= exp_next;
            search_reg <= search_next;
            since_reg <= since_next;
            probes_reg <= probes_next;
            phase_reg <= phase_next;
            drive_reg <= drive_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/pps_drive_binary_search_loop.sv -----
// Top level: input register, search core and result register.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    op, phase_diff, new_mode, direct_drive
//  rsp      out  valid/ready    drive_written .. settle_count
//  cfg      in   cfg_we         cfg_wdata = step_threshold
//
// An item goes from the input register to the result register; one item per cycle while rsp is ready.
// The state update is one 8-bit add, two signed compares and one 16-bit add/sub.
// Reset: auto mode, drive and search 0xFFFF, exponent 15, threshold 10.
// A stalled rsp holds the result register; req stays ready while the
// input register is empty or moving on.
`timescale 1ns / 1ps
`default_nettype none

module pps_drive_binary_search_loop
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    pps_bsl_in_if.sink          req,
    pps_bsl_out_if.source       rsp,
    input  wire logic           cfg_we,
    input  wire logic [6:0]     cfg_wdata
);

    logic                       in_vld_reg;
    pps_bsl_pkg::in_item_t      in_data_reg;
    logic                       out_vld_reg;
    pps_bsl_pkg::out_item_t     out_data_reg;
    pps_bsl_pkg::out_item_t     core_res;
    logic                       advance;

    assign advance = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_data_reg <= req.data;
        end
    end

    pps_bsl_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_go   (advance),
        .item      (in_data_reg),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_res;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data = out_data_reg;

`ifndef SYNTHESIS
    a_no_overwrite_in: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && in_vld_reg) |-> advance)
        else $error("input register overwritten while holding an item");

    a_no_overwrite_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !rsp.ready) |-> !advance)
        else $error("result register overwritten while stalled");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("processed item did not reach the result register");

    a_step_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && u_core.exp_reg == 4'd0) |-> (core_res.step_position == 4'd0
            || core_res.step_position == pps_bsl_pkg::STEP_EXP_RESET))
        else $error("step exponent left the floor without a re-arm");
`endif

endmodule

`default_nettype wire
